[rtl/core/mcsg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle span generator package
// Shared widths, the command item and the span result item.
// ----------------------------------------------------------------------------
package mcsg_pkg;

  localparam int unsigned MAX_RADIUS  = 60;
  localparam int unsigned COORD_BITS  = 10;
  localparam int unsigned RADIUS_BITS = 6;
  localparam int unsigned OUT_BITS    = COORD_BITS + 2;
  localparam int unsigned STEP_BITS   = 7;
  localparam int unsigned ODD_BITS    = 8;
  localparam int unsigned ERR_BITS    = 10;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [COORD_BITS-1:0]  col;
    logic [COORD_BITS-1:0]  row;
    logic [RADIUS_BITS-1:0] radius;
  } circle_cmd_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] wide_top_row;
    logic signed [OUT_BITS-1:0] wide_bottom_row;
    logic signed [OUT_BITS-1:0] wide_left;
    logic signed [OUT_BITS-1:0] wide_right;
    logic signed [OUT_BITS-1:0] narrow_top_row;
    logic signed [OUT_BITS-1:0] narrow_bottom_row;
    logic signed [OUT_BITS-1:0] narrow_left;
    logic signed [OUT_BITS-1:0] narrow_right;
    logic                       last_span;
  } span_t;

endpackage

[rtl/core/mcsg_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command front end
// Accepts circle commands, clamps the radius and drops zero-radius circles.
// ----------------------------------------------------------------------------
module mcsg_front import mcsg_pkg::*; (
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [COORD_BITS-1:0]  center_col_i,
  input  logic [COORD_BITS-1:0]  center_row_i,
  input  logic [RADIUS_BITS-1:0] circle_radius_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output circle_cmd_t            q_cmd_o
);

  logic [RADIUS_BITS-1:0] radius_clamped;

  assign radius_clamped = (circle_radius_i > RADIUS_BITS'(MAX_RADIUS)) ?
                          RADIUS_BITS'(MAX_RADIUS) : circle_radius_i;

  assign in_stall_o     = q_full_i;
  assign q_push_o       = in_valid_i && !q_full_i && (circle_radius_i != '0);
  assign q_cmd_o.col    = center_col_i;
  assign q_cmd_o.row    = center_row_i;
  assign q_cmd_o.radius = radius_clamped;

endmodule

[rtl/core/mcsg_cmd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// A short first-in first-out queue between the front end and the span engine.
// ----------------------------------------------------------------------------
module mcsg_cmd_queue import mcsg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  circle_cmd_t push_cmd_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        empty_o,
  output circle_cmd_t pop_cmd_o
);

  circle_cmd_t          entry_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0] count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o    = (count_q == QCNT_BITS'(QUEUE_DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_cmd_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == QCNT_BITS'(QUEUE_DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not follow a push");
`endif

endmodule

[rtl/core/mcsg_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span engine
// Runs one midpoint circle iteration per cycle while not stalled and registers each span item.
// ----------------------------------------------------------------------------
module mcsg_engine import mcsg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  circle_cmd_t q_cmd_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output span_t       span_o
);

  logic                         busy_q;
  logic [STEP_BITS-1:0]         step_x_q, step_y_q;
  logic [ODD_BITS-1:0]          odd_x_q, odd_y_q;
  logic signed [ERR_BITS-1:0]   err_q;
  logic [RADIUS_BITS:0]         diam_q;
  logic [COORD_BITS-1:0]        col_q, row_q;
  logic                         out_valid_q;
  span_t                        span_q;

  logic                         load;
  logic                         step_en;
  logic signed [ERR_BITS-1:0]   err_a, err_b;
  logic [STEP_BITS-1:0]         y_nxt;
  logic [ODD_BITS-1:0]          odd_y_nxt, odd_x_nxt;
  logic signed [STEP_BITS:0]    x_nxt;
  logic                         last;
  logic signed [OUT_BITS-1:0]   row_e, col_e, x_e, y_e;
  span_t                        span_d;

  assign load    = !out_valid_q || !out_stall_i;
  assign step_en = busy_q && load;
  assign q_pop_o = !busy_q && !q_empty_i;

  always_comb begin
    err_a     = err_q;
    y_nxt     = step_y_q;
    odd_y_nxt = odd_y_q;
    if (err_q <= 0) begin
      y_nxt     = step_y_q + 1'b1;
      err_a     = err_q + $signed({{(ERR_BITS - ODD_BITS){1'b0}}, odd_y_q});
      odd_y_nxt = odd_y_q + ODD_BITS'(2);
    end
    err_b     = err_a;
    x_nxt     = $signed({1'b0, step_x_q});
    odd_x_nxt = odd_x_q;
    if (err_a > 0) begin
      x_nxt     = $signed({1'b0, step_x_q}) - $signed((STEP_BITS + 1)'(1));
      odd_x_nxt = odd_x_q + ODD_BITS'(2);
      err_b     = err_a + $signed({{(ERR_BITS - ODD_BITS){1'b0}}, odd_x_nxt})
                        - $signed({{(ERR_BITS - RADIUS_BITS - 1){1'b0}}, diam_q});
    end
    last = x_nxt < $signed({1'b0, y_nxt});
  end

  assign row_e = $signed(OUT_BITS'(row_q));
  assign col_e = $signed(OUT_BITS'(col_q));
  assign x_e   = $signed(OUT_BITS'(step_x_q));
  assign y_e   = $signed(OUT_BITS'(step_y_q));

  always_comb begin
    span_d.wide_top_row      = row_e - y_e;
    span_d.wide_bottom_row   = row_e + y_e;
    span_d.wide_left         = col_e - x_e;
    span_d.wide_right        = col_e + x_e;
    span_d.narrow_top_row    = row_e - x_e;
    span_d.narrow_bottom_row = row_e + x_e;
    span_d.narrow_left       = col_e - y_e;
    span_d.narrow_right      = col_e + y_e;
    span_d.last_span         = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        busy_q <= 1'b1;
      end else if (step_en && last) begin
        busy_q <= 1'b0;
      end
      if (step_en) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      step_x_q <= STEP_BITS'(q_cmd_i.radius) - 1'b1;
      step_y_q <= '0;
      odd_x_q  <= ODD_BITS'(1);
      odd_y_q  <= ODD_BITS'(1);
      err_q    <= $signed(ERR_BITS'(1)) - $signed(ERR_BITS'({q_cmd_i.radius, 1'b0}));
      diam_q   <= {q_cmd_i.radius, 1'b0};
      col_q    <= q_cmd_i.col;
      row_q    <= q_cmd_i.row;
    end else if (step_en) begin
      step_x_q <= x_nxt[STEP_BITS-1:0];
      step_y_q <= y_nxt;
      odd_x_q  <= odd_x_nxt;
      odd_y_q  <= odd_y_nxt;
      err_q    <= err_b;
    end
    if (step_en) begin
      span_q <= span_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign span_o      = span_q;

`ifndef NO_ASSERTIONS
  a_loop_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (step_y_q <= step_x_q))
    else $error("step y passed step x while busy");

  a_diam_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (diam_q >= (RADIUS_BITS + 1)'(2) &&
                diam_q <= (RADIUS_BITS + 1)'(2 * MAX_RADIUS)))
    else $error("diameter out of range while busy");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en && last) |=> (!busy_q && out_valid_q && span_q.last_span))
    else $error("final span did not end the circle");
`endif

endmodule

[rtl/core/midpoint_circle_span_generator_top.sv]
`timescale 1ns / 1ps
// A command that meets an idle engine is written into the queue, loaded into
// the engine, which then registers its first span item. Throughput: one span
// item per cycle while the output is not stalled; the engine takes the next
// command only after the last span of a circle; zero radius takes none. Reset
// is asynchronous and clears the queue, the engine busy flag and the output valid.
// ----------------------------------------------------------------------------
// Midpoint circle span generator
// Front end, command queue and span engine of the circle fill generator.
// ----------------------------------------------------------------------------
module midpoint_circle_span_generator_top import mcsg_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [COORD_BITS-1:0]      center_col_i,
  input  logic [COORD_BITS-1:0]      center_row_i,
  input  logic [RADIUS_BITS-1:0]     circle_radius_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [OUT_BITS-1:0] wide_top_row_o,
  output logic signed [OUT_BITS-1:0] wide_bottom_row_o,
  output logic signed [OUT_BITS-1:0] wide_left_o,
  output logic signed [OUT_BITS-1:0] wide_right_o,
  output logic signed [OUT_BITS-1:0] narrow_top_row_o,
  output logic signed [OUT_BITS-1:0] narrow_bottom_row_o,
  output logic signed [OUT_BITS-1:0] narrow_left_o,
  output logic signed [OUT_BITS-1:0] narrow_right_o,
  output logic                       last_span_o
);

  logic        q_full, q_push, q_empty, q_pop;
  circle_cmd_t push_cmd, pop_cmd;
  span_t       span;

  mcsg_front u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .center_col_i    (center_col_i),
    .center_row_i    (center_row_i),
    .circle_radius_i (circle_radius_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (push_cmd)
  );

  mcsg_cmd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_cmd_o  (pop_cmd)
  );

  mcsg_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_cmd_i     (pop_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .span_o      (span)
  );

  assign wide_top_row_o      = span.wide_top_row;
  assign wide_bottom_row_o   = span.wide_bottom_row;
  assign wide_left_o         = span.wide_left;
  assign wide_right_o        = span.wide_right;
  assign narrow_top_row_o    = span.narrow_top_row;
  assign narrow_bottom_row_o = span.narrow_bottom_row;
  assign narrow_left_o       = span.narrow_left;
  assign narrow_right_o      = span.narrow_right;
  assign last_span_o         = span.last_span;

endmodule
